// ===== sv/spld_pkg.sv =====
`default_nettype none
package spld_pkg;

   localparam int ChanW    = 3;
   localparam int BinW     = 12;
   localparam int PartW    = 32;
   localparam int LevelW   = 17;
   localparam int WinW     = 4;
   localparam int MagW     = 31;
   localparam int RadW     = 62;
   localparam int RemW     = 33;
   localparam int SqSteps  = 31;
   localparam int LogSteps = 20;
   localparam int LgW      = 22;

   localparam logic [LevelW-1:0] LevelOne   = 17'd65536;
   localparam logic [LevelW-1:0] LevelFloor = 17'd66;
   localparam logic [31:0]       Log10x2Q32 = 32'd2585827973;
   localparam logic [WinW-1:0]   WinMin     = 4'd7;
   localparam logic [WinW-1:0]   WinMax     = 4'd13;
   localparam logic [WinW-1:0]   WinReset   = 4'd10;

   typedef enum logic [0:0] {
      CSR_WINDOW    = 1'b0,
      CSR_SMOOTHING = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic              valid;
      logic              in_range;
      logic [ChanW-1:0]  channel;
      logic [BinW-1:0]   bin;
   } tag_type;

   typedef struct packed {
      tag_type           tag;
      logic              force_one;
      logic              is_dc;
      logic [MagW-1:0]   dc_mag;
   } side_type;

endpackage
`default_nettype wire

// ===== sv/spld_if.sv =====
`default_nettype none
interface spld_req_if import spld_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [ChanW-1:0]        channel;
   logic [BinW-1:0]         bin;
   logic signed [PartW-1:0] real_part;
   logic signed [PartW-1:0] imag_part;
   modport source (output valid, channel, bin, real_part, imag_part, input ready);
   modport sink   (input valid, channel, bin, real_part, imag_part, output ready);
endinterface

interface spld_rsp_if import spld_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ChanW-1:0]  out_channel;
   logic [BinW-1:0]   out_bin;
   logic [LevelW-1:0] level;
   modport source (output valid, out_channel, out_bin, level, input ready);
   modport sink   (input valid, out_channel, out_bin, level, output ready);
endinterface

interface spld_csr_if import spld_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [0:0]        index;
   logic [LevelW-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== sv/spld_front.sv =====
`default_nettype none
module spld_front import spld_pkg::*; #(
   parameter int MAX_CHANNELS = 8,
   parameter int MAX_BINS     = 4096
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    en,
   input  wire logic                    accept,
   input  wire logic [ChanW-1:0]        channel,
   input  wire logic [BinW-1:0]         bin,
   input  wire logic signed [PartW-1:0] real_part,
   input  wire logic signed [PartW-1:0] imag_part,
   input  wire logic [WinW-1:0]         win,
   output side_type                     side_out,
   output logic [RadW-1:0]              rad_out
);

   logic [PartW-1:0] re_raw, im_raw, re_abs, im_abs;
   logic             in_range;

   tag_type          tag0_ff, tag1_ff, tag2_ff, tag3_ff;
   logic [31:0]      re0_ff, im0_ff, re1_ff, re2_ff, re3_ff;
   logic [63:0]      sqr1_ff, sqi1_ff, p2_ff;
   logic [76:0]      prod3_ff;
   side_type         side4_ff;
   logic [RadW-1:0]  rad4_ff;

   logic [6:0]       nd_shift, rad_shift;
   logic [4:0]       dc_shift, dc_lsh;
   logic             force_nd, force_dc, is_dc;
   logic [MagW-1:0]  dc_mag;
   logic [12:0]      mult;

   assign re_raw = real_part;
   assign im_raw = imag_part;
   assign re_abs = re_raw[31] ? (~re_raw + 32'd1) : re_raw;
   assign im_abs = im_raw[31] ? (~im_raw + 32'd1) : im_raw;
   assign in_range = (32'(channel) < 32'(MAX_CHANNELS)) && (32'(bin) < 32'(MAX_BINS))
                     && ((bin >> (win - 4'd1)) == '0);

   assign mult      = 13'(tag2_ff.bin) + 13'd1;
   assign nd_shift  = 7'({win, 1'b0}) + 7'd28;
   assign rad_shift = 7'd34 - 7'({win, 1'b0});
   assign dc_shift  = 5'(win) + 5'd15;
   assign dc_lsh    = 5'd16 - 5'(win);
   assign force_nd  = |(prod3_ff >> nd_shift);
   assign force_dc  = |(re3_ff >> dc_shift);
   assign dc_mag    = MagW'(re3_ff << dc_lsh);
   assign is_dc     = (tag3_ff.bin == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         tag0_ff  <= '0;
         tag1_ff  <= '0;
         tag2_ff  <= '0;
         tag3_ff  <= '0;
         side4_ff <= '0;
      end else if (en) begin
         tag0_ff  <= '{valid: accept, in_range: in_range, channel: channel, bin: bin};
         tag1_ff  <= tag0_ff;
         tag2_ff  <= tag1_ff;
         tag3_ff  <= tag2_ff;
         side4_ff <= '{tag: tag3_ff, force_one: is_dc ? force_dc : force_nd,
                       is_dc: is_dc, dc_mag: dc_mag};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         re0_ff   <= re_abs;
         im0_ff   <= im_abs;
         sqr1_ff  <= 64'(re0_ff) * 64'(re0_ff);
         sqi1_ff  <= 64'(im0_ff) * 64'(im0_ff);
         re1_ff   <= re0_ff;
         p2_ff    <= sqr1_ff + sqi1_ff;
         re2_ff   <= re1_ff;
         prod3_ff <= 77'(p2_ff) * 77'(mult);
         re3_ff   <= re2_ff;
         rad4_ff  <= RadW'(prod3_ff << rad_shift);
      end
   end

   assign side_out = side4_ff;
   assign rad_out  = rad4_ff;

endmodule
`default_nettype wire

// ===== sv/spld_sqrt.sv =====
`default_nettype none
module spld_sqrt import spld_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            en,
   input  wire logic [RadW-1:0] rad,
   input  side_type             side_in,
   output logic [MagW-1:0]      mag,
   output side_type             side_out
);

   logic [RemW-1:0] rem_ff  [1:SqSteps];
   logic [MagW-1:0] root_ff [1:SqSteps];
   logic [RadW-1:0] rad_ff  [1:SqSteps];
   side_type        side_ff [1:SqSteps];

   for (genvar g = 0; g < SqSteps; g++) begin : g_step
      logic [RemW-1:0] rem_prev, rem_sh, trial;
      logic [MagW-1:0] root_prev;
      logic [RadW-1:0] rad_prev;
      side_type        side_prev;

      if (g == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = rad;
         assign side_prev = side_in;
      end else begin : g_next
         assign rem_prev  = rem_ff[g];
         assign root_prev = root_ff[g];
         assign rad_prev  = rad_ff[g];
         assign side_prev = side_ff[g];
      end

      assign rem_sh = {rem_prev[30:0], rad_prev[RadW-1-2*g -: 2]};
      assign trial  = {root_prev[30:0], 2'b01};

      always_ff @(posedge clock) begin
         if (reset) begin
            side_ff[g+1] <= '0;
         end else if (en) begin
            side_ff[g+1] <= side_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[g+1] <= rad_prev;
            if (rem_sh >= trial) begin
               rem_ff[g+1]  <= rem_sh - trial;
               root_ff[g+1] <= {root_prev[29:0], 1'b1};
            end else begin
               rem_ff[g+1]  <= rem_sh;
               root_ff[g+1] <= {root_prev[29:0], 1'b0};
            end
         end
      end
   end

   assign side_out = side_ff[SqSteps];
   assign mag      = side_ff[SqSteps].is_dc ? side_ff[SqSteps].dc_mag : root_ff[SqSteps];

endmodule
`default_nettype wire

// ===== sv/spld_log.sv =====
`default_nettype none
module spld_log import spld_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            en,
   input  wire logic [MagW-1:0] mag,
   input  side_type             side_in,
   output logic [LevelW-1:0]    raw,
   output tag_type              tag_out
);

   logic [32:0]     y_in;
   logic [30:0]     y_ff   [0:LogSteps];
   logic [LgW-1:0]  lg_ff  [0:LogSteps];
   tag_type         tag_ff [0:LogSteps];
   logic            frc_ff [0:LogSteps];

   logic [54:0]     lv_prod;
   logic [18:0]     lv_ff;
   tag_type         tag_m_ff, tag_r_ff;
   logic            frc_m_ff;
   logic [LevelW-1:0] raw_ff;

   assign y_in = 33'h040000000 + {1'b0, mag, 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff[0] <= '0;
      end else if (en) begin
         tag_ff[0] <= side_in.tag;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         frc_ff[0] <= side_in.force_one;
         if (y_in[32]) begin
            y_ff[0]  <= y_in[32:2];
            lg_ff[0] <= LgW'(2);
         end else if (y_in[31]) begin
            y_ff[0]  <= y_in[31:1];
            lg_ff[0] <= LgW'(1);
         end else begin
            y_ff[0]  <= y_in[30:0];
            lg_ff[0] <= '0;
         end
      end
   end

   for (genvar g = 1; g <= LogSteps; g++) begin : g_sq
      logic [61:0] sq;
      logic [31:0] t;
      assign sq = 62'(y_ff[g-1]) * 62'(y_ff[g-1]);
      assign t  = sq[61:30];

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[g] <= '0;
         end else if (en) begin
            tag_ff[g] <= tag_ff[g-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            frc_ff[g] <= frc_ff[g-1];
            if (t[31]) begin
               y_ff[g]  <= t[31:1];
               lg_ff[g] <= {lg_ff[g-1][LgW-2:0], 1'b1};
            end else begin
               y_ff[g]  <= t[30:0];
               lg_ff[g] <= {lg_ff[g-1][LgW-2:0], 1'b0};
            end
         end
      end
   end

   assign lv_prod = 55'(lg_ff[LogSteps]) * 55'(Log10x2Q32) + (55'd1 << 35);

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_m_ff <= '0;
         tag_r_ff <= '0;
      end else if (en) begin
         tag_m_ff <= tag_ff[LogSteps];
         tag_r_ff <= tag_m_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lv_ff    <= lv_prod[54:36];
         frc_m_ff <= frc_ff[LogSteps];
         if (frc_m_ff || (lv_ff > 19'(LevelOne))) begin
            raw_ff <= LevelOne;
         end else if (lv_ff < 19'(LevelFloor)) begin
            raw_ff <= '0;
         end else begin
            raw_ff <= lv_ff[LevelW-1:0];
         end
      end
   end

   assign raw     = raw_ff;
   assign tag_out = tag_r_ff;

endmodule
`default_nettype wire

// ===== sv/spld_store.sv =====
`default_nettype none
module spld_store import spld_pkg::*; #(
   parameter int MAX_CHANNELS = 8,
   parameter int MAX_BINS     = 4096
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic [LevelW-1:0] raw,
   input  tag_type                tag,
   input  wire logic [LevelW-1:0] smooth,
   output logic                   clear_busy,
   output logic                   out_valid,
   output logic [ChanW-1:0]       out_channel,
   output logic [BinW-1:0]        out_bin,
   output logic [LevelW-1:0]      out_level
);

   localparam int Depth = MAX_CHANNELS * MAX_BINS;
   localparam int AddrW = $clog2(Depth);

   logic [LevelW-1:0] mem [Depth];

   logic [AddrW-1:0]  addr_r;
   logic [LevelW-1:0] rdata_ff, raw_b_ff, old, blend, result;
   logic [AddrW-1:0]  addr_b_ff;
   tag_type           tag_b_ff;
   logic              fwd_valid_ff;
   logic [AddrW-1:0]  fwd_addr_ff;
   logic [LevelW-1:0] fwd_data_ff;
   logic              clr_busy_ff;
   logic [AddrW-1:0]  clr_cnt_ff;
   logic [33:0]       acc;
   logic              item_wr, wr_en;
   logic [AddrW-1:0]  wr_addr;
   logic [LevelW-1:0] wr_data;

   logic              out_valid_ff;
   logic [ChanW-1:0]  out_channel_ff;
   logic [BinW-1:0]   out_bin_ff;
   logic [LevelW-1:0] out_level_ff;

   assign addr_r = AddrW'(32'(tag.channel) * MAX_BINS + 32'(tag.bin));

   assign old    = (fwd_valid_ff && (fwd_addr_ff == addr_b_ff)) ? fwd_data_ff : rdata_ff;
   assign acc    = 34'(smooth) * 34'(old) + 34'(LevelOne - smooth) * 34'(raw_b_ff)
                   + 34'd32768;
   assign blend  = acc[32:16];
   assign result = !tag_b_ff.in_range ? '0 : ((raw_b_ff >= old) ? raw_b_ff : blend);

   assign item_wr = en && tag_b_ff.valid && tag_b_ff.in_range;
   assign wr_en   = clr_busy_ff || item_wr;
   assign wr_addr = clr_busy_ff ? clr_cnt_ff : addr_b_ff;
   assign wr_data = clr_busy_ff ? '0 : result;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (en) begin
         rdata_ff <= mem[addr_r];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else if (clr_busy_ff) begin
         clr_cnt_ff <= clr_cnt_ff + AddrW'(1);
         if (clr_cnt_ff == AddrW'(Depth - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_b_ff     <= '0;
         fwd_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         tag_b_ff     <= tag;
         fwd_valid_ff <= tag_b_ff.valid && tag_b_ff.in_range;
         out_valid_ff <= tag_b_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         raw_b_ff       <= raw;
         addr_b_ff      <= addr_r;
         fwd_addr_ff    <= addr_b_ff;
         fwd_data_ff    <= result;
         out_channel_ff <= tag_b_ff.channel;
         out_bin_ff     <= tag_b_ff.bin;
         out_level_ff   <= result;
      end
   end

   assign clear_busy  = clr_busy_ff;
   assign out_valid   = out_valid_ff;
   assign out_channel = out_channel_ff;
   assign out_bin     = out_bin_ff;
   assign out_level   = out_level_ff;

endmodule
`default_nettype wire

// ===== sv/spectrum_level_peak_decay_unit.sv =====
// Spectrum level with peak hold and decay.
// req_bus carries one FFT bin per transfer (channel, bin, real and imaginary
// parts); rsp_bus returns its channel, bin and smoothed Q16 level, one result
// per bin, in order. csr_bus writes window_size_log2 (index 0) and smoothing
// (index 1); values are saturated to their legal range. Write only when idle.
// Throughput: one bin per clock while rsp_bus takes results and the RAM is not
// being cleared. Each result passes the front end, the 31-step square root
// pipeline, the 20 squaring steps of the log2 pipeline and the level store.
// The level store is one synchronous RAM of MAX_CHANNELS*MAX_BINS entries,
// read into a register ahead of the blend and written back after it;
// back-to-back hits on the same entry are forwarded.
// After reset the RAM is swept to zero, one entry a cycle, over all
// MAX_CHANNELS*MAX_BINS entries (32768 by default); req_bus.ready stays low
// meanwhile. CSR writes are taken at any time.
// When the receiver holds off with a result waiting, the whole pipeline
// freezes and req_bus.ready drops until that result is taken.
`default_nettype none
module spectrum_level_peak_decay_unit import spld_pkg::*; #(
   parameter int MAX_CHANNELS = 8,
   parameter int MAX_BINS     = 4096
) (
   input wire logic    clock,
   input wire logic    reset,
   spld_req_if.sink    req_bus,
   spld_rsp_if.source  rsp_bus,
   spld_csr_if.sink    csr_bus
);

   logic [WinW-1:0]   win_ff;
   logic [LevelW-1:0] smooth_ff;
   logic              en, accept, clear_busy;

   side_type          front_side, sqrt_side;
   logic [RadW-1:0]   front_rad;
   logic [MagW-1:0]   mag;
   logic [LevelW-1:0] raw;
   tag_type           log_tag;

   assign en            = !rsp_bus.valid || rsp_bus.ready;
   assign req_bus.ready = en && !clear_busy;
   assign accept        = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff    <= WinReset;
         smooth_ff <= '0;
      end else if (csr_bus.valid) begin
         case (csr_index_type'(csr_bus.index))
            CSR_WINDOW: begin
               if (csr_bus.data[3:0] < WinMin) begin
                  win_ff <= WinMin;
               end else if (csr_bus.data[3:0] > WinMax) begin
                  win_ff <= WinMax;
               end else begin
                  win_ff <= csr_bus.data[3:0];
               end
            end
            CSR_SMOOTHING: begin
               smooth_ff <= (csr_bus.data > LevelOne) ? LevelOne : csr_bus.data;
            end
            default: begin
               win_ff <= win_ff;
            end
         endcase
      end
   end

   spld_front #(.MAX_CHANNELS(MAX_CHANNELS), .MAX_BINS(MAX_BINS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .accept    (accept),
      .channel   (req_bus.channel),
      .bin       (req_bus.bin),
      .real_part (req_bus.real_part),
      .imag_part (req_bus.imag_part),
      .win       (win_ff),
      .side_out  (front_side),
      .rad_out   (front_rad)
   );

   spld_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .rad      (front_rad),
      .side_in  (front_side),
      .mag      (mag),
      .side_out (sqrt_side)
   );

   spld_log u_log (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .mag     (mag),
      .side_in (sqrt_side),
      .raw     (raw),
      .tag_out (log_tag)
   );

   spld_store #(.MAX_CHANNELS(MAX_CHANNELS), .MAX_BINS(MAX_BINS)) u_store (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .raw         (raw),
      .tag         (log_tag),
      .smooth      (smooth_ff),
      .clear_busy  (clear_busy),
      .out_valid   (rsp_bus.valid),
      .out_channel (rsp_bus.out_channel),
      .out_bin     (rsp_bus.out_bin),
      .out_level   (rsp_bus.level)
   );

   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> !req_bus.ready)
      else $error("request taken during store clear");

   a_level_max: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.level <= LevelOne))
      else $error("level above full scale");

   a_bin_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && (32'(rsp_bus.out_bin) >= 32'(MAX_BINS))) |-> (rsp_bus.level == '0))
      else $error("nonzero level for bin outside store");

endmodule
`default_nettype wire

// ===== dv/spectrum_level_peak_decay_unit_tb.sv =====
`default_nettype none
module spectrum_level_peak_decay_unit_tb import spld_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NumChan    = 8;
   localparam int NumBins    = 4096;
   localparam int Latency    = 60;
   localparam int CycleLimit = 400000;
   localparam int PhaseItems = 200;
   localparam int HoldCycles = 300;

   typedef struct packed {
      logic [ChanW-1:0]  channel;
      logic [BinW-1:0]   bin;
      logic [LevelW-1:0] level;
   } level_rec_type;

   typedef struct packed {
      logic [ChanW-1:0]        channel;
      logic [BinW-1:0]         bin;
      logic signed [PartW-1:0] re;
      logic signed [PartW-1:0] im;
      logic                    known;
      logic [LevelW-1:0]       level;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   spld_req_if req_bus ();
   spld_rsp_if rsp_bus ();
   spld_csr_if csr_bus ();

   spectrum_level_peak_decay_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   logic [3:0]        win_log2 = WinReset;
   logic [16:0]       smooth_q16 = '0;
   logic [LevelW-1:0] level_store [NumChan*NumBins];
   level_rec_type     pending_levels [$];
   int                failures = 0;
   int                cycles = 0;
   int                sent = 0;
   bit                no_idle = 1'b0;
   bit                hold_done = 1'b0;
   bit                stim_done = 1'b0;

   task automatic report(input string what);
      failures++;
      $display("mismatch @%0t: %s", $realtime, what);
   endtask

   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v = v - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   function automatic logic [LevelW-1:0] log_level(input logic [63:0] mq);
      logic [63:0] y, lg, lv;
      y = ((64'd1 << 31) + 4 * mq) >> 1;
      lg = 0;
      while (y >= (64'd1 << 31)) begin
         y = y >> 1;
         lg++;
      end
      for (int i = 0; i < LogSteps; i++) begin
         y = (y * y) >> 30;
         lg = lg << 1;
         if (y >= (64'd1 << 31)) begin
            y = y >> 1;
            lg[0] = 1'b1;
         end
      end
      lv = (lg * 64'(Log10x2Q32) + (64'd1 << 35)) >> 36;
      if (lv > 64'(LevelOne)) return LevelOne;
      if (lv < 64'(LevelFloor)) return '0;
      return lv[LevelW-1:0];
   endfunction

   function automatic logic [63:0] mag32(input logic [31:0] raw);
      logic [63:0] v;
      v = {32'b0, raw};
      if (v[31]) v = 64'h1_0000_0000 - v;
      return v;
   endfunction

   // updates the level store as the block does
   function automatic logic [LevelW-1:0] smoothed_level(input logic [ChanW-1:0] ch,
         input logic [BinW-1:0] k, input logic [31:0] re_raw, input logic [31:0] im_raw);
      logic [63:0]  re, im, p, w, acc;
      logic [127:0] wide;
      logic [LevelW-1:0] raw, old, res;
      int idx;
      if (32'(k) >= (32'd1 << (win_log2 - 1))) return '0;
      idx = int'(ch) * NumBins + int'(k);
      old = level_store[idx];
      re = mag32(re_raw);
      im = mag32(im_raw);
      if (k == 0) begin
         if (re >= (64'd1 << (win_log2 + 15))) raw = LevelOne;
         else raw = log_level(re << (16 - win_log2));
      end else begin
         p = re * re + im * im;
         wide = 128'(p) * 128'(k + 64'd1);
         if (wide[127:64] != 0) begin
            raw = LevelOne;
         end else begin
            w = wide[63:0];
            if ((w >> (2 * win_log2 + 28)) != 0) raw = LevelOne;
            else raw = log_level(isqrt64(w << (34 - 2 * win_log2)));
         end
      end
      if (raw >= old) begin
         res = raw;
      end else begin
         acc = 64'(smooth_q16) * old + (64'd65536 - smooth_q16) * raw + 64'd32768;
         res = acc[16+LevelW-1:16];
      end
      level_store[idx] = res;
      return res;
   endfunction

   task automatic send_bin(input logic [ChanW-1:0] ch, input logic [BinW-1:0] k,
         input logic [31:0] re, input logic [31:0] im, input bit known,
         input logic [LevelW-1:0] lvl);
      level_rec_type rec;
      logic [LevelW-1:0] pred;
      while (!no_idle && $urandom_range(0, 99) < 31) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.channel   <= ch;
      req_bus.bin       <= k;
      req_bus.real_part <= re;
      req_bus.imag_part <= im;
      do @(posedge clock); while (!req_bus.ready);
      pred = smoothed_level(ch, k, re, im);
      rec.channel = ch;
      rec.bin = k;
      rec.level = known ? lvl : pred;
      pending_levels.push_back(rec);
      sent++;
      // valid stays high; the idle path of the next call or drain lowers it
   endtask

   task automatic drain;
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_levels.size() != 0) @(posedge clock);
      repeat (Latency + 10) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [LevelW-1:0] val);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= val;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      if (idx == CSR_WINDOW) begin
         win_log2 = val[3:0] < WinMin ? WinMin : (val[3:0] > WinMax ? WinMax : val[3:0]);
      end else begin
         smooth_q16 = val > LevelOne ? LevelOne : val;
      end
      @(posedge clock);
   endtask

   function automatic logic [31:0] rand_part();
      logic [31:0] v;
      case ($urandom_range(0, 3))
         0: v = $urandom;
         1: v = $urandom >> $urandom_range(0, 31);
         2: v = $urandom_range(0, 40000);
         default: v = 32'($urandom_range(0, 70000)) >> $urandom_range(0, 16);
      endcase
      if ($urandom_range(0, 1)) v = -v;
      return v;
   endfunction

   task automatic random_bins(input int n);
      int              half;
      logic [BinW-1:0] k;
      for (int i = 0; i < n; i++) begin
         half = 1 << (win_log2 - 1);
         case ($urandom_range(0, 9))
            0: k = BinW'($urandom_range(0, 4095));
            1: k = '0;
            2, 3, 4: k = BinW'($urandom_range(0, 3));
            default: k = BinW'($urandom_range(0, half - 1));
         endcase
         no_idle = (sent >= 500 && sent < 650);
         send_bin(ChanW'($urandom_range(0, 7)), k, rand_part(), rand_part(), 1'b0, '0);
      end
   endtask

   dir_row_type dir_rows [15];

   initial begin
      for (int i = 0; i < NumChan * NumBins; i++) level_store[i] = '0;
      req_bus.valid <= 1'b0;
      req_bus.channel <= '0;
      req_bus.bin <= '0;
      req_bus.real_part <= '0;
      req_bus.imag_part <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.index <= CSR_WINDOW;
      csr_bus.data <= '0;
      dir_rows = '{
         '{3'd0, 12'd0,    32'sh0,        32'sh0,        1'b1, 17'd0},
         '{3'd1, 12'd0,    32'sh7fffffff, 32'sh0,        1'b1, LevelOne},
         '{3'd1, 12'd0,    32'sh0,        32'sh0,        1'b1, 17'd0},
         '{3'd2, 12'd511,  32'sh80000000, 32'sh80000000, 1'b1, LevelOne},
         '{3'd2, 12'd512,  32'sh1234,     32'sh5678,     1'b1, 17'd0},
         '{3'd7, 12'd4095, 32'shffffffff, 32'sh7fffffff, 1'b1, 17'd0},
         '{3'd3, 12'd1,    32'sh1,        -32'sh1,       1'b0, 17'd0},
         '{3'd3, 12'd1,    32'sh8000,     32'sh0,        1'b0, 17'd0},
         '{3'd4, 12'd0,    -32'sh8000,    32'sh7fffffff, 1'b0, 17'd0},
         '{3'd5, 12'd255,  32'sh64,       -32'sh64,      1'b0, 17'd0},
         '{3'd5, 12'd255,  32'sh0,        32'sh0,        1'b0, 17'd0},
         '{3'd6, 12'd10,   32'sh7fffffff, 32'sh0,        1'b1, LevelOne},
         '{3'd6, 12'd10,   32'shc,        32'sh5,        1'b0, 17'd0},
         '{3'd0, 12'd3,    32'sh3e8,      32'sh7d0,      1'b0, 17'd0},
         '{3'd0, 12'd3,    -32'sh3e8,     32'sh0,        1'b0, 17'd0}
      };
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      foreach (dir_rows[i])
         send_bin(dir_rows[i].channel, dir_rows[i].bin, dir_rows[i].re, dir_rows[i].im,
                  dir_rows[i].known, dir_rows[i].level);
      random_bins(PhaseItems - 15);
      drain();
      write_reg(CSR_WINDOW, 17'd7);
      write_reg(CSR_SMOOTHING, 17'd65536);
      random_bins(PhaseItems);
      drain();
      write_reg(CSR_WINDOW, 17'd13);
      write_reg(CSR_SMOOTHING, 17'd32768);
      random_bins(PhaseItems);
      drain();
      write_reg(CSR_WINDOW, 17'h1_fff9);
      write_reg(CSR_SMOOTHING, 17'h1_ffff);
      random_bins(PhaseItems);
      drain();
      write_reg(CSR_WINDOW, 17'd15);
      write_reg(CSR_SMOOTHING, 17'd1000);
      random_bins(PhaseItems);
      drain();
      write_reg(CSR_WINDOW, 17'd3);
      write_reg(CSR_SMOOTHING, 17'd0);
      random_bins(PhaseItems);
      drain();
      write_reg(CSR_WINDOW, 17'd11);
      write_reg(CSR_SMOOTHING, 17'd60000);
      random_bins(PhaseItems);
      stim_done = 1'b1;
      drain();
      if (failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      rsp_bus.ready <= 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!hold_done && sent >= 900) begin
            hold_done = 1'b1;
            rsp_bus.ready <= 1'b0;
            for (int c = 0; c < HoldCycles; c++) @(posedge clock);
         end
         rsp_bus.ready <= no_idle || stim_done || $urandom_range(0, 99) >= 31;
      end
   end

   always @(posedge clock) begin
      level_rec_type want;
      cycles++;
      if (cycles > CycleLimit) begin
         $display("TEST FAILED");
         $finish;
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_levels.size() == 0) begin
            report($sformatf("unexpected transfer ch %0d bin %0d", rsp_bus.out_channel,
                             rsp_bus.out_bin));
         end else begin
            want = pending_levels.pop_front();
            if (rsp_bus.out_channel !== want.channel)
               report($sformatf("channel %0d, want %0d", rsp_bus.out_channel, want.channel));
            if (rsp_bus.out_bin !== want.bin)
               report($sformatf("bin %0d, want %0d", rsp_bus.out_bin, want.bin));
            if (rsp_bus.level !== want.level)
               report($sformatf("level %0d, want %0d (ch %0d bin %0d)", rsp_bus.level,
                                want.level, want.channel, want.bin));
         end
      end
   end

endmodule
`default_nettype wire

// ===== files.f =====
sv/spld_pkg.sv
sv/spld_if.sv
sv/spld_front.sv
sv/spld_sqrt.sv
sv/spld_log.sv
sv/spld_store.sv
sv/spectrum_level_peak_decay_unit.sv
dv/spectrum_level_peak_decay_unit_tb.sv
